/* rtl/node_table_id_range_allocator_macros.svh */
// Assertion macros used by the checker file
`ifndef NODE_TABLE_ID_RANGE_ALLOCATOR_MACROS_SVH
`define NODE_TABLE_ID_RANGE_ALLOCATOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define NTA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define NTA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nta_pkg.sv */
// ----------------------------------------------------------------------------
// nta_pkg
// Types, codes and helpers shared by the member table allocator modules.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int MAX_LOGS_DEF  = 4;
    localparam int ID_WIDTH_DEF  = 11;
    localparam int SIZE_FIELDS   = 4;
    localparam int ID_UNIT_LOG2  = 6;

    // action codes
    localparam logic [1:0] ACT_JOIN    = 2'd0;
    localparam logic [1:0] ACT_KICK_ID = 2'd1;
    localparam logic [1:0] ACT_KICK_SL = 2'd2;

    // status codes
    localparam logic [2:0] ST_JOINED   = 3'd0;
    localparam logic [2:0] ST_MEMBER   = 3'd1;
    localparam logic [2:0] ST_NOROOM   = 3'd2;
    localparam logic [2:0] ST_KICKED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // register indexes
    localparam logic RIDX_RESERVED = 1'b0;
    localparam logic RIDX_LIMIT    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEED,
        S_SCAN,
        S_GAP_FIND,
        S_GAP_EVAL,
        S_GAP_STEP,
        S_APPEND,
        S_MOVE,
        S_DONE
    } nta_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic need_step;   // add one log's demand
        logic scan_clr;    // reset the scan index
        logic scan_step;   // advance the scan index
        logic gap_init;    // start the gap walk
        logic gap_find;    // look for next range start
        logic gap_eval;    // evaluate the current gap
        logic append;      // write the new member
        logic move;        // copy last entry into the hit slot
        logic set_status;  // latch a status
        logic [2:0] status;
    } nta_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic need_done;
        logic scan_done;
        logic scan_hit;
        logic full;
        logic gap_last;
        logic found;
    } nta_sts_t;

    // identifiers needed by one log
    function automatic logic [10:0] ids_for_size(input logic [15:0] sz);
        logic [10:0] q;
        q = {1'b0, sz[15:ID_UNIT_LOG2]};
        if (sz == 16'd0)
            ids_for_size = 11'd1;
        else if (sz[ID_UNIT_LOG2-1:0] != '0)
            ids_for_size = q + 11'd1;
        else
            ids_for_size = q;
    endfunction

endpackage

/* rtl/nta_ctrl.sv */
// ----------------------------------------------------------------------------
// nta_ctrl
// Sequencer for the member table: duplicate scan, gap walk, append, kick.
// ----------------------------------------------------------------------------
module nta_ctrl
    import nta_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_beat,
    input  logic     out_free,
    input  nta_sts_t sts,
    output logic     busy,
    output logic     done,
    output nta_cmd_t cmd
);

    nta_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) state_next = S_NEED;
            end
            S_NEED: begin
                if (sts.action == ACT_JOIN) begin
                    if (sts.need_done) state_next = S_SCAN;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.action == ACT_JOIN) begin
                    if (sts.scan_hit) state_next = S_DONE;
                    else if (sts.scan_done) state_next = sts.full ? S_DONE : S_GAP_FIND;
                end else if (sts.action == ACT_KICK_ID || sts.action == ACT_KICK_SL) begin
                    if (sts.scan_hit) state_next = S_MOVE;
                    else if (sts.scan_done) state_next = S_DONE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_GAP_FIND: begin
                if (sts.scan_done) state_next = S_GAP_EVAL;
            end
            S_GAP_EVAL: begin
                state_next = S_GAP_STEP;
            end
            S_GAP_STEP: begin
                if (sts.gap_last) state_next = S_APPEND;
                else state_next = S_GAP_FIND;
            end
            S_APPEND: begin
                state_next = S_DONE;
            end
            S_MOVE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                busy     = 1'b0;
                cmd.load = in_beat;
            end
            S_NEED: begin
                cmd.need_step = (sts.action == ACT_JOIN);
                cmd.scan_clr  = 1'b1;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.action == ACT_JOIN) begin
                    if (sts.scan_hit) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_MEMBER;
                    end else if (sts.scan_done) begin
                        cmd.scan_clr   = 1'b1;
                        cmd.gap_init   = 1'b1;
                        cmd.set_status = sts.full;
                        cmd.status     = ST_NOROOM;
                    end
                end else if (sts.action == ACT_KICK_ID || sts.action == ACT_KICK_SL) begin
                    if (sts.scan_hit) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_KICKED;
                    end else if (sts.scan_done) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_NOTFOUND;
                    end
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOTFOUND;
                end
            end
            S_GAP_FIND: begin
                cmd.gap_find  = 1'b1;
                cmd.scan_step = 1'b1;
            end
            S_GAP_EVAL: begin
                cmd.gap_eval = 1'b1;
            end
            S_GAP_STEP: begin
                cmd.scan_clr = 1'b1;
            end
            S_APPEND: begin
                cmd.set_status = 1'b1;
                cmd.status     = sts.found ? ST_JOINED : ST_NOROOM;
                cmd.append     = sts.found;
            end
            S_MOVE: begin
                cmd.move = 1'b1;
            end
            S_DONE: begin
                done = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/nta_dpath.sv */
// ----------------------------------------------------------------------------
// nta_dpath
// Member table registers, demand adder and the ordered gap walk.
// The gap walk visits ranges in start order (ties by table index) by picking,
// each round, the smallest (start, index) pair above the previous one.
// ----------------------------------------------------------------------------
module nta_dpath
    import nta_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_LOGS  = MAX_LOGS_DEF,
    parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nta_cmd_t             cmd,
    output nta_sts_t             sts,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [11:0]          cfg_data,
    input  logic [1:0]           in_action,
    input  logic [63:0]          in_board_id,
    input  logic [15:0]          in_slot,
    input  logic [7:0]           in_board_type,
    input  logic [2:0]           in_log_count,
    input  logic [4*16-1:0]      in_sizes,
    output logic [2:0]           res_status,
    output logic [10:0]          res_start,
    output logic [11:0]          res_end,
    output logic [7:0]           res_base,
    output logic [4:0]           res_count
);

    localparam int IW   = $clog2(MAX_NODES);
    localparam int IXW  = (IW < 1) ? 1 : IW;
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int VW   = ID_WIDTH + 1;
    localparam int CAP  = (MAX_LOGS < SIZE_FIELDS) ? MAX_LOGS : SIZE_FIELDS;
    localparam logic [VW:0] TOP = (VW+1)'(1) << ID_WIDTH;

    // member table
    logic [63:0]         ids_reg   [MAX_NODES];
    logic [15:0]         slots_reg [MAX_NODES];
    logic [7:0]          types_reg [MAX_NODES];
    logic [VW-1:0]       starts_reg[MAX_NODES];
    logic [VW-1:0]       ends_reg  [MAX_NODES];
    logic [2:0]          lcnt_reg  [MAX_NODES];
    logic [7:0]          lbase_reg [MAX_NODES];
    logic [CW-1:0]       count_reg;
    logic [7:0]          next_log_reg;
    logic [VW-1:0]       rtop_reg;
    logic [VW-1:0]       limit_reg;

    // item and scratch
    logic [1:0]          act_reg;
    logic [63:0]         id_reg;
    logic [15:0]         slot_reg;
    logic [7:0]          type_reg;
    logic [2:0]          logs_reg;
    logic [4*16-1:0]     sizes_reg;
    logic [2:0]          nidx_reg;
    logic [VW+2:0]       need_reg;
    logic [CW-1:0]       scan_reg;
    logic [IXW-1:0]      hit_reg;
    logic [VW-1:0]       prev_reg;
    logic                have_last_reg;
    logic [VW-1:0]       last_start_reg;
    logic [IXW-1:0]      last_idx_reg;
    logic                cand_reg;
    logic [VW-1:0]       cand_start_reg;
    logic [IXW-1:0]      cand_idx_reg;
    logic                found_reg;
    logic [VW-1:0]       best_room_reg;
    logic [VW-1:0]       best_start_reg;
    logic [2:0]          status_reg;
    logic [10:0]         ostart_reg;
    logic [11:0]         oend_reg;
    logic [7:0]          obase_reg;

    logic [IXW-1:0]      sidx;
    logic                entry_hit;
    logic                after_last;
    logic                better;
    logic [VW-1:0]       gap_end;
    logic [VW-1:0]       room;
    logic [IXW-1:0]      last_ent;
    logic [2:0]          logs_cap;
    logic [15:0]         cur_size;

    assign sidx     = scan_reg[IXW-1:0];
    assign last_ent = IXW'(count_reg - CW'(1));
    assign logs_cap = (in_log_count > 3'(CAP)) ? 3'(CAP) : in_log_count;
    assign cur_size = sizes_reg[nidx_reg[1:0]*16 +: 16];

    // entry compare for the current scan index
    always_comb begin
        if (act_reg == ACT_KICK_SL) entry_hit = (slots_reg[sidx] == slot_reg);
        else entry_hit = (ids_reg[sidx] == id_reg);
    end

    // ordering of (start, index) pairs for the gap walk
    always_comb begin
        after_last = !have_last_reg ||
            (starts_reg[sidx] > last_start_reg) ||
            (starts_reg[sidx] == last_start_reg && sidx > last_idx_reg);
        better = !cand_reg || (starts_reg[sidx] < cand_start_reg);
    end

    assign gap_end = cand_reg ? starts_reg[cand_idx_reg] : limit_reg;
    assign room    = gap_end - prev_reg;

    always_comb begin
        sts             = '0;
        sts.action      = act_reg;
        sts.need_done   = (nidx_reg >= logs_reg);
        sts.scan_done   = (scan_reg >= count_reg);
        sts.scan_hit    = (scan_reg < count_reg) && entry_hit;
        sts.full        = (count_reg >= CW'(MAX_NODES));
        sts.gap_last    = !cand_reg;
        sts.found       = found_reg;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtop_reg  <= VW'(15);
            limit_reg <= VW'(((2047 > (1 << ID_WIDTH)) ? (1 << ID_WIDTH) : 2047));
        end else if (cfg_we) begin
            if (cfg_idx == RIDX_RESERVED) begin
                rtop_reg <= VW'(cfg_data[10:0] & 11'((1 << ID_WIDTH) - 1));
            end else if ({1'b0, cfg_data} > TOP[12:0]) begin
                limit_reg <= VW'(TOP);
            end else begin
                limit_reg <= VW'(cfg_data);
            end
        end
    end

    // control-state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            next_log_reg <= '0;
        end else if (cmd.append) begin
            count_reg    <= count_reg + CW'(1);
            next_log_reg <= next_log_reg + 8'(logs_reg);
        end else if (cmd.move) begin
            count_reg    <= count_reg - CW'(1);
        end
    end

    // table writes: append or move last into the hit slot
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            ids_reg[IXW'(count_reg)]    <= id_reg;
            slots_reg[IXW'(count_reg)]  <= slot_reg;
            types_reg[IXW'(count_reg)]  <= type_reg;
            starts_reg[IXW'(count_reg)] <= best_start_reg;
            ends_reg[IXW'(count_reg)]   <= VW'(best_start_reg + need_reg[VW-1:0]);
            lcnt_reg[IXW'(count_reg)]   <= logs_reg;
            lbase_reg[IXW'(count_reg)]  <= next_log_reg;
        end else if (cmd.move) begin
            ids_reg[hit_reg]    <= ids_reg[last_ent];
            slots_reg[hit_reg]  <= slots_reg[last_ent];
            types_reg[hit_reg]  <= types_reg[last_ent];
            starts_reg[hit_reg] <= starts_reg[last_ent];
            ends_reg[hit_reg]   <= ends_reg[last_ent];
            lcnt_reg[hit_reg]   <= lcnt_reg[last_ent];
            lbase_reg[hit_reg]  <= lbase_reg[last_ent];
        end
    end

    // item capture, demand sum, scan and gap walk
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= in_action;
            id_reg    <= in_board_id;
            slot_reg  <= in_slot;
            type_reg  <= in_board_type;
            logs_reg  <= logs_cap;
            sizes_reg <= in_sizes;
            nidx_reg  <= '0;
            need_reg  <= '0;
            ostart_reg <= '0;
            oend_reg  <= '0;
            obase_reg <= '0;
        end
        if (cmd.need_step && nidx_reg < logs_reg) begin
            need_reg <= need_reg + (VW+3)'(ids_for_size(cur_size));
            nidx_reg <= nidx_reg + 3'd1;
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
            cand_reg <= 1'b0;
        end else if (cmd.scan_step && scan_reg < count_reg) begin
            scan_reg <= scan_reg + CW'(1);
            hit_reg  <= sidx;
        end
        if (cmd.gap_init) begin
            prev_reg      <= rtop_reg + VW'(1);
            have_last_reg <= 1'b0;
            found_reg     <= 1'b0;
            best_room_reg <= '0;
            best_start_reg <= '0;
        end
        if (cmd.gap_find && scan_reg < count_reg && after_last && better) begin
            cand_reg       <= 1'b1;
            cand_start_reg <= starts_reg[sidx];
            cand_idx_reg   <= sidx;
        end
        if (cmd.gap_eval) begin
            if (gap_end >= prev_reg && prev_reg < limit_reg &&
                {3'b0, room} >= need_reg && (!found_reg || room < best_room_reg)) begin
                found_reg      <= 1'b1;
                best_room_reg  <= room;
                best_start_reg <= prev_reg;
            end
            if (cand_reg) begin
                have_last_reg  <= 1'b1;
                last_start_reg <= cand_start_reg;
                last_idx_reg   <= cand_idx_reg;
                if (ends_reg[cand_idx_reg] > prev_reg) prev_reg <= ends_reg[cand_idx_reg];
            end
        end
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.append) begin
            ostart_reg <= 11'(best_start_reg);
            oend_reg   <= 12'(best_start_reg + need_reg[VW-1:0]);
            obase_reg  <= next_log_reg;
        end
    end

    assign res_status = status_reg;
    assign res_start  = ostart_reg;
    assign res_end    = oend_reg;
    assign res_base   = obase_reg;
    assign res_count  = 5'(count_reg);

endmodule

/* rtl/node_table_id_range_allocator.sv */
// ----------------------------------------------------------------------------
// node_table_id_range_allocator
// Member table with best-fit identifier range allocation.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per request (join, kick by id, kick by slot).
// Result channel m_*: exactly one beat per request, in order.
// Configuration: cfg_we/cfg_idx/cfg_data write reserved_top (0) or id_limit
// (1); write only while the block is idle.
// A kick scans the table of N members for its target. A join sums the demand
// of its L logs, scans for a duplicate and then walks the gaps: each gap step
// rescans the table for the next range start; a full table of sixteen
// refuses right after the duplicate scan.
// One item is worked on at a time; s_ready rises again once the result beat
// is taken. A stalled m_ready holds the result and the block.
// Reset clears the member count, log index, configuration and state; table
// entries are not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module node_table_id_range_allocator
    import nta_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_LOGS  = MAX_LOGS_DEF,
    parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_board_id,
    input  logic [15:0] s_slot,
    input  logic [7:0]  s_board_type,
    input  logic [2:0]  s_log_count,
    input  logic [15:0] s_log_size_0,
    input  logic [15:0] s_log_size_1,
    input  logic [15:0] s_log_size_2,
    input  logic [15:0] s_log_size_3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [10:0] m_range_start,
    output logic [11:0] m_range_end,
    output logic [7:0]  m_first_log_index,
    output logic [4:0]  m_node_count
);

    nta_cmd_t cmd;
    nta_sts_t sts;
    logic     busy;
    logic     done;

    assign s_ready = !busy;
    assign m_valid = done;

    nta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (s_valid && s_ready),
        .out_free (m_ready),
        .sts      (sts),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    nta_dpath #(
        .MAX_NODES (MAX_NODES),
        .MAX_LOGS  (MAX_LOGS),
        .ID_WIDTH  (ID_WIDTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .in_action     (s_action),
        .in_board_id   (s_board_id),
        .in_slot       (s_slot),
        .in_board_type (s_board_type),
        .in_log_count  (s_log_count),
        .in_sizes      ({s_log_size_3, s_log_size_2, s_log_size_1, s_log_size_0}),
        .res_status    (m_status),
        .res_start     (m_range_start),
        .res_end       (m_range_end),
        .res_base      (m_first_log_index),
        .res_count     (m_node_count)
    );

endmodule

/* rtl/nta_checker.sv */
// ----------------------------------------------------------------------------
// nta_checker
// Port-level checks for the member table allocator.
// ----------------------------------------------------------------------------
`include "node_table_id_range_allocator_macros.svh"

module nta_checker
    import nta_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [10:0] m_range_start,
    input logic [4:0]  m_node_count
);

    `NTA_ASSERT_IMP(a_one_side, aclk, aresetn, m_valid, !s_ready, "input open with result pending")
    `NTA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status), "result dropped under stall")
    `NTA_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status <= ST_NOTFOUND, "bad status code")
    `NTA_ASSERT_IMP(a_zero_fields, aclk, aresetn, m_valid && m_status != ST_JOINED, m_range_start == 11'd0, "range on failed item")
    `NTA_ASSERT_IMP(a_count, aclk, aresetn, m_valid, m_node_count <= 5'd16, "count over capacity")

endmodule

bind node_table_id_range_allocator nta_checker u_nta_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_range_start (m_range_start),
    .m_node_count  (m_node_count)
);
